/* hdl/bbof_pkg.sv */
// bbof_pkg: shared types and constants for the billboard offset and fade block
// no dependencies
`timescale 1ns / 1ps
package bbof_pkg;
    localparam int FRACTION_BITS = 16;
    localparam logic [33:0] NEAR_LSB = 34'(((64'd1 << FRACTION_BITS) + 64'd5000) / 64'd10000);
    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_OFFSET = 4'h0;
    localparam logic [ADDR_W-1:0] REG_FADE   = 4'h4;
    localparam logic [ADDR_W-1:0] REG_ALPHA  = 4'h8;

    typedef struct packed {
        logic        camera_present;
        logic [31:0] cam_x;
        logic [31:0] cam_y;
        logic [31:0] cam_z;
        logic [31:0] item_x;
        logic [31:0] item_y;
        logic [31:0] item_z;
    } bbof_in_t;

    typedef struct packed {
        logic        position_written;
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] new_z;
        logic        alpha_written;
        logic [16:0] alpha_out;
    } bbof_out_t;

    // shared divider / root unit control
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [67:0] num;
        logic [33:0] den;
    } bbof_du_req_t;

    typedef struct packed {
        logic        done;
        logic [67:0] quot;
    } bbof_du_rsp_t;
endpackage

/* hdl/bbof_if.sv */
// bbof_if: valid/ready channel carrying one transaction payload
// depends on bbof_pkg
`timescale 1ns / 1ps
interface bbof_in_if;
    import bbof_pkg::*;
    logic     valid;
    logic     ready;
    bbof_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bbof_out_if;
    import bbof_pkg::*;
    logic      valid;
    logic      ready;
    bbof_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/bbof_divroot.sv */
// bbof_divroot: bit-serial restoring divider and integer square root
// depends on bbof_pkg
`timescale 1ns / 1ps
module bbof_divroot
    import bbof_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bbof_du_req_t req,
    output bbof_du_rsp_t rsp
);
    logic [67:0] num_reg, num_next;
    logic [69:0] rem_reg, rem_next;
    logic [67:0] q_reg, q_next;
    logic [33:0] den_reg, den_next;
    logic        sq_reg, sq_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [69:0] rshift, trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rshift    = '0;
        trial     = '0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            sq_next   = req.is_sqrt;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = req.is_sqrt ? 7'd34 : 7'd68;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                // two bits of radicand per step
                rshift   = {rem_reg[67:0], num_reg[67:66]};
                trial    = {q_reg[67:0], 2'b01};
                num_next = {num_reg[65:0], 2'b00};
                if (rshift >= trial)
                begin
                    rem_next = rshift - trial;
                    q_next   = {q_reg[66:0], 1'b1};
                end
                else
                begin
                    rem_next = rshift;
                    q_next   = {q_reg[66:0], 1'b0};
                end
            end
            else
            begin
                rshift   = {rem_reg[68:0], num_reg[67]};
                trial    = {36'd0, den_reg};
                num_next = {num_reg[66:0], 1'b0};
                if (rshift >= trial)
                begin
                    rem_next = rshift - trial;
                    q_next   = {q_reg[66:0], 1'b1};
                end
                else
                begin
                    rem_next = rshift;
                    q_next   = {q_reg[66:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        sq_reg  <= sq_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
endmodule

/* hdl/billboard_offset_and_fade.sv */
// billboard_offset_and_fade: top level with sequencer, registers and apb port
// depends on bbof_pkg, bbof_if, bbof_divroot
`timescale 1ns / 1ps
// One transaction per frame: the block takes camera and item positions,
// optionally pulls the anchored quad toward the camera by offset_distance
// and computes a proximity-faded alpha. All roots and divides run through one
// shared bit-serial unit (68 steps per divide, 34 per square root) under a
// sequencer; squares and the pull product use small multipliers of about
// 33x33 bits. With both features on, a transaction uses up to 2 roots and
// 4 divides. ready is low while a transaction is in work and while the
// result waits to be taken; it rises the cycle after the result is taken.
// Registers: 0x0 offset_distance, 0x4 fade_distance, 0x8 base_alpha.
module billboard_offset_and_fade
    import bbof_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bbof_in_if.sink           in_ch,
    bbof_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CHECK  = 12'b000000000010,
        S_SQ     = 12'b000000000100,
        S_ROOT   = 12'b000000001000,
        S_RWAIT  = 12'b000000010000,
        S_DIV    = 12'b000000100000,
        S_DWAIT  = 12'b000001000000,
        S_FSQ    = 12'b000010000000,
        S_FROOT  = 12'b000100000000,
        S_FWAIT  = 12'b001000000000,
        S_ADIV   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [30:0] offset_reg;
    logic [30:0] fade_reg;
    logic [16:0] base_reg;
    logic        wr_en;

    // state of the model
    logic signed [31:0] anchor_reg [3];
    logic signed [31:0] last_reg [3];
    logic               held_reg;

    // transaction context
    bbof_in_t           item_reg;
    logic signed [32:0] delta_reg [3];
    logic [67:0]        sum_reg;
    logic [1:0]         axis_reg;
    logic [33:0]        dist_reg;
    logic signed [31:0] pos_reg [3];
    bbof_out_t          res_reg;
    logic               res_valid_reg;

    bbof_du_req_t du_req;
    bbof_du_rsp_t du_rsp;

    bbof_divroot u_du (.clk(clk), .rst_n(rst_n), .req(du_req), .rsp(du_rsp));

    logic signed [31:0] cam_a [3];
    logic signed [31:0] itm_a [3];
    assign cam_a[0] = item_reg.cam_x;
    assign cam_a[1] = item_reg.cam_y;
    assign cam_a[2] = item_reg.cam_z;
    assign itm_a[0] = item_reg.item_x;
    assign itm_a[1] = item_reg.item_y;
    assign itm_a[2] = item_reg.item_z;

    // apb port, writes on the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr)
            REG_OFFSET: prdata = {1'b0, offset_reg};
            REG_FADE:   prdata = {1'b0, fade_reg};
            REG_ALPHA:  prdata = {15'd0, base_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            fade_reg   <= '0;
            base_reg   <= 17'd65536;
        end
        else if (wr_en)
        begin
            if (paddr == REG_OFFSET)
                offset_reg <= pwdata[30:0];
            if (paddr == REG_FADE)
                fade_reg <= pwdata[30:0];
            if (paddr == REG_ALPHA)
                base_reg <= pwdata[16:0];
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    // re-capture test on the current item against the last written point
    logic moved;
    always_comb
    begin
        moved = !held_reg;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [32:0] df;
            logic [32:0]        dm;
            df = 33'(itm_a[i]) - 33'(last_reg[i]);
            dm = df[32] ? 33'(-df) : df;
            if (34'(dm) > NEAR_LSB)
                moved = 1'b1;
        end
    end

    // one square per cycle on the selected axis
    logic [32:0] mag_sel;
    logic [65:0] sq_val;
    always_comb
    begin
        logic signed [32:0] dsel;
        dsel    = delta_reg[axis_reg];
        mag_sel = dsel[32] ? 33'(-dsel) : dsel;
        sq_val  = 66'(mag_sel) * 66'(mag_sel);
    end

    logic [63:0] mul_num;
    assign mul_num = 64'(mag_sel) * 64'(offset_reg);

    // saturating add of the signed quotient to the anchor
    logic signed [69:0] newc;
    logic signed [31:0] newc_sat;
    always_comb
    begin
        logic signed [69:0] sq;
        sq = $signed({2'b00, du_rsp.quot});
        if (delta_reg[axis_reg][32])
            sq = -sq;
        newc = 70'(anchor_reg[axis_reg]) + sq;
        if (newc > 70'sh7FFFFFFF)
            newc_sat = 32'sh7FFFFFFF;
        else if (newc < -70'sh80000000)
            newc_sat = -32'sh80000000;
        else
            newc_sat = newc[31:0];
    end

    always_comb
    begin
        du_req.start   = 1'b0;
        du_req.is_sqrt = 1'b0;
        du_req.num     = '0;
        du_req.den     = '0;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_ch.valid && in_ch.ready) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!item_reg.camera_present)
                    state_next = S_OUT;
                else if (offset_reg != '0)
                    state_next = S_SQ;
                else if (fade_reg != '0)
                    state_next = S_FSQ;
                else
                    state_next = S_OUT;
            end
            S_SQ:     if (axis_reg == 2'd2) state_next = S_ROOT;
            S_ROOT:
            begin
                du_req.start   = 1'b1;
                du_req.is_sqrt = 1'b1;
                du_req.num     = sum_reg;
                state_next     = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (du_rsp.done)
                begin
                    if (du_rsp.quot[33:0] > NEAR_LSB)
                        state_next = S_DIV;
                    else if (fade_reg != '0)
                        state_next = S_FSQ;
                    else
                        state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                du_req.start = 1'b1;
                du_req.num   = 68'(mul_num);
                du_req.den   = dist_reg;
                state_next   = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (du_rsp.done)
                begin
                    if (axis_reg != 2'd2)
                        state_next = S_DIV;
                    else if (fade_reg != '0)
                        state_next = S_FSQ;
                    else
                        state_next = S_OUT;
                end
            end
            S_FSQ:    if (axis_reg == 2'd2) state_next = S_FROOT;
            S_FROOT:
            begin
                du_req.start   = 1'b1;
                du_req.is_sqrt = 1'b1;
                du_req.num     = sum_reg;
                state_next     = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (du_rsp.done)
                begin
                    if (du_rsp.quot[33:0] <= 34'(fade_reg) ||
                        du_rsp.quot[33:0] - 34'(fade_reg) >= 34'(fade_reg))
                        state_next = S_OUT;
                    else
                        state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                if (du_rsp.done)
                    state_next = S_OUT;
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        // alpha ramp divide is launched as the root finishes
        if (state_reg == S_FWAIT && du_rsp.done && state_next == S_ADIV)
        begin
            du_req.start = 1'b1;
            du_req.num   = 68'(base_reg) * 68'(du_rsp.quot[33:0] - 34'(fade_reg));
            du_req.den   = 34'(fade_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                anchor_reg[i] <= '0;
                last_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.valid && out_ch.ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CHECK:
                begin
                    if (item_reg.camera_present && offset_reg != '0 && moved)
                    begin
                        for (int i = 0; i < 3; i++)
                            anchor_reg[i] <= itm_a[i];
                        held_reg <= 1'b1;
                    end
                end
                S_DWAIT:
                begin
                    if (du_rsp.done && axis_reg == 2'd2)
                    begin
                        for (int i = 0; i < 3; i++)
                            last_reg[i] <= (i == 2) ? newc_sat : pos_reg[i];
                    end
                end
                S_OUT:    res_valid_reg <= 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    item_reg <= in_ch.data;
                    res_reg  <= '0;
                end
            end
            S_CHECK:
            begin
                axis_reg <= 2'd0;
                sum_reg  <= '0;
                for (int i = 0; i < 3; i++)
                    delta_reg[i] <= (offset_reg != '0 && moved) || !held_reg
                                    ? 33'(cam_a[i]) - 33'(itm_a[i])
                                    : 33'(cam_a[i]) - 33'(anchor_reg[i]);
            end
            S_SQ, S_FSQ:
            begin
                sum_reg  <= sum_reg + 68'(sq_val);
                axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
            end
            S_RWAIT:
            begin
                if (du_rsp.done)
                begin
                    dist_reg <= du_rsp.quot[33:0];
                    axis_reg <= 2'd0;
                    sum_reg  <= '0;
                end
            end
            S_DWAIT:
            begin
                if (du_rsp.done)
                begin
                    pos_reg[axis_reg] <= newc_sat;
                    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        res_reg.position_written <= 1'b1;
                        res_reg.new_x <= pos_reg[0];
                        res_reg.new_y <= pos_reg[1];
                        res_reg.new_z <= newc_sat;
                        sum_reg <= '0;
                    end
                end
            end
            S_FWAIT:
            begin
                if (du_rsp.done)
                begin
                    dist_reg <= du_rsp.quot[33:0];
                    res_reg.alpha_written <= 1'b1;
                    if (du_rsp.quot[33:0] <= 34'(fade_reg))
                        res_reg.alpha_out <= '0;
                    else
                        res_reg.alpha_out <= base_reg;
                end
            end
            S_ADIV:
            begin
                if (du_rsp.done)
                    res_reg.alpha_out <= du_rsp.quot[16:0];
            end
            default: ;
        endcase
        // fade distance uses the anchor after any re-capture
        if (state_reg == S_RWAIT && du_rsp.done)
        begin
            for (int i = 0; i < 3; i++)
                delta_reg[i] <= 33'(cam_a[i]) - 33'(anchor_reg[i]);
        end
        if (state_reg == S_DWAIT && du_rsp.done && axis_reg == 2'd2)
        begin
            for (int i = 0; i < 3; i++)
                delta_reg[i] <= 33'(cam_a[i]) - 33'(anchor_reg[i]);
        end
    end
endmodule

/* hdl/bbof_checker.sv */
// bbof_checker: port-level assertions for billboard_offset_and_fade
// depends on bbof_pkg; bound to the top level
`timescale 1ns / 1ps
module bbof_checker
    import bbof_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input bbof_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted while busy");
    a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.position_written |->
        out_data.new_x == '0 && out_data.new_y == '0 && out_data.new_z == '0)
        else $error("position fields set without write flag");
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.alpha_written |-> out_data.alpha_out == '0)
        else $error("alpha set without write flag");
endmodule

bind billboard_offset_and_fade bbof_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);
